### rtl/life_grid_generation_engine_macros.svh
// assertion shorthands used by the engine
`ifndef LIFE_GRID_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_MACROS_SVH

// same-cycle implication on the engine clock
`define LGE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on the engine clock
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lge_pkg.sv
`default_nettype none

package lge_pkg;

	// field widths fixed by the interface
	localparam int XY_W  = 5;
	localparam int OP_W  = 2;
	localparam int CFG_W = 6;

	localparam logic [CFG_W-1:0] CFG_SIDE_RESET = 6'd32;
	localparam int MIN_SIDE = 3;

	// B3/S23 rule
	localparam int NBR_COUNT     = 8;
	localparam int NBR_W         = $clog2(NBR_COUNT + 1);
	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_COUNT = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_TOGGLE = 2'd1,
		OP_READ   = 2'd2,
		OP_STEP   = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		CFG_FIELD_WIDTH = 1'b0,
		CFG_FIELD_DEPTH = 1'b1
	} cfg_idx_t;

endpackage

`default_nettype wire

### rtl/lge_req_if.sv
`default_nettype none

interface lge_req_if
	import lge_pkg::*;
	;
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] func;
	logic [XY_W-1:0] cell_x;
	logic [XY_W-1:0] cell_y;

	modport source (output valid, output func, output cell_x, output cell_y, input ready);
	modport sink (input valid, input func, input cell_x, input cell_y, output ready);
endinterface

`default_nettype wire

### rtl/lge_rsp_if.sv
`default_nettype none

interface lge_rsp_if
	import lge_pkg::*;
	;
	logic            valid;
	logic            ready;
	logic            cell_alive;
	logic [OP_W-1:0] op_done;

	modport source (output valid, output cell_alive, output op_done, input ready);
	modport sink (input valid, input cell_alive, input op_done, output ready);
endinterface

`default_nettype wire

### rtl/lge_row.sv
`default_nettype none

// next generation of one row from the rows north, center and south of it
module lge_row
	import lge_pkg::*;
#(
	parameter int MAX_SIDE = 32
) (
	input  wire logic [MAX_SIDE-1:0]                north,
	input  wire logic [MAX_SIDE-1:0]                cent,
	input  wire logic [MAX_SIDE-1:0]                south,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]      width,
	output logic      [MAX_SIDE-1:0]                next_row
);

	localparam int RW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);

	logic [RW-1:0] last_col;
	logic          n_last;
	logic          c_last;
	logic          s_last;

	// west neighbor of column 0 is the last in-use column
	assign last_col = RW'(width - SW'(1));
	assign n_last   = north[last_col];
	assign c_last   = cent[last_col];
	assign s_last   = south[last_col];

	for (genvar x = 0; x < MAX_SIDE; x++) begin : g_col
		logic             wn, wc, ws;
		logic             en, ec, es;
		logic [NBR_W-1:0] cnt;

		if (x == 0) begin : g_west_wrap
			assign wn = n_last;
			assign wc = c_last;
			assign ws = s_last;
		end else begin : g_west
			assign wn = north[x-1];
			assign wc = cent[x-1];
			assign ws = south[x-1];
		end

		if (x == MAX_SIDE - 1) begin : g_east_wrap
			assign en = north[0];
			assign ec = cent[0];
			assign es = south[0];
		end else begin : g_east
			logic at_edge;
			assign at_edge = (SW'(x + 1) == width);
			assign en      = at_edge ? north[0] : north[x+1];
			assign ec      = at_edge ? cent[0]  : cent[x+1];
			assign es      = at_edge ? south[0] : south[x+1];
		end

		assign cnt = NBR_W'(wn) + NBR_W'(north[x]) + NBR_W'(en)
			+ NBR_W'(wc) + NBR_W'(ec)
			+ NBR_W'(ws) + NBR_W'(south[x]) + NBR_W'(es);

		// columns past the field come out dead
		assign next_row[x] = (SW'(x) < width)
			&& ((cnt == NBR_W'(BIRTH_COUNT)) || (cent[x] && (cnt == NBR_W'(SURVIVE_COUNT))));
	end

endmodule

`default_nettype wire

### rtl/life_grid_generation_engine.sv
// toggle and read fetch the row as the transfer is taken, then go through the access and finish
// states; clear passes over every row; step streams the rows and zeroes any rows below the field
// step rate is one row per cycle through the single read port of the grid memory
// one operation in flight; the next transfer is taken the cycle after the result is loaded
// reset: clearing pass over every row of the current grid with ready low; config resets to 32 by 32
`default_nettype none
`include "life_grid_generation_engine_macros.svh"

module life_grid_generation_engine
	import lge_pkg::*;
#(
	parameter int MAX_SIDE = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	lge_req_if.sink               req,
	lge_rsp_if.source             rsp
);

	localparam int RW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = $clog2(MAX_SIDE + 2);
	localparam int KW = (SW > CFG_W) ? SW : CFG_W;
	localparam int AW = RW + 1;
	localparam int XW = RW + XY_W;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_ACC,
		ST_STEP,
		ST_ZERO,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  cfg_width_q;
	logic [CFG_W-1:0]  cfg_depth_q;
	logic              cur_q;
	op_t               func_q;
	logic              in_field_q;
	logic [RW-1:0]     cx_q;
	logic [RW-1:0]     cy_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     rd_cnt_q;
	logic [CW-1:0]     arr_cnt_q;
	logic              res_alive_q;
	logic              clr_reply_q;
	logic              rsp_valid_q;
	logic              rsp_alive_q;
	op_t               rsp_op_q;
	logic              rd_v_s1;
	logic [MAX_SIDE-1:0] rdata_s1;
	logic [MAX_SIDE-1:0] north_q;
	logic [MAX_SIDE-1:0] cent_q;

	logic [MAX_SIDE-1:0] mem [0:(2**AW)-1];

	logic [KW-1:0]       raw_w;
	logic [KW-1:0]       raw_d;
	logic [SW-1:0]       eff_w;
	logic [SW-1:0]       eff_d;
	logic [XW-1:0]       cx_wide;
	logic [XW-1:0]       cy_wide;
	logic                accept;
	logic                in_field;
	logic [CW-1:0]       d_plus1;
	logic                step_issue;
	logic [RW-1:0]       step_row;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [MAX_SIDE-1:0] mem_wdata;
	logic                row_wr;
	logic [MAX_SIDE-1:0] next_row;
	logic [MAX_SIDE-1:0] flip_mask;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q <= CFG_SIDE_RESET;
			cfg_depth_q <= CFG_SIDE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FIELD_WIDTH: cfg_width_q <= cfg_data;
				CFG_FIELD_DEPTH: cfg_depth_q <= cfg_data;
			endcase
		end
	end

	// saturate the field size into MIN_SIDE..MAX_SIDE
	assign raw_w = KW'(cfg_width_q);
	assign raw_d = KW'(cfg_depth_q);

	always_comb begin
		priority if (raw_w < KW'(MIN_SIDE)) eff_w = SW'(MIN_SIDE);
		else if (raw_w > KW'(MAX_SIDE)) eff_w = SW'(MAX_SIDE);
		else eff_w = SW'(raw_w);
		priority if (raw_d < KW'(MIN_SIDE)) eff_d = SW'(MIN_SIDE);
		else if (raw_d > KW'(MAX_SIDE)) eff_d = SW'(MAX_SIDE);
		else eff_d = SW'(raw_d);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign cx_wide   = XW'(req.cell_x);
	assign cy_wide   = XW'(req.cell_y);
	assign in_field  = (KW'(req.cell_x) < KW'(eff_w)) && (KW'(req.cell_y) < KW'(eff_d));

	// step reads rows d-1, 0 .. d-1, 0 so every row sees wrapped north and south
	assign d_plus1    = CW'(eff_d) + CW'(1);
	assign step_issue = (state_q == ST_STEP) && (rd_cnt_q <= d_plus1);

	always_comb begin
		priority if (rd_cnt_q == '0) step_row = RW'(eff_d - SW'(1));
		else if (rd_cnt_q == d_plus1) step_row = '0;
		else step_row = RW'(rd_cnt_q - CW'(1));
	end

	assign mem_re    = accept || step_issue;
	assign mem_raddr = accept ? {cur_q, cy_wide[RW-1:0]} : {cur_q, step_row};

	// a new row is ready once north and center are held
	assign row_wr = rd_v_s1 && (arr_cnt_q >= CW'(2));

	lge_row #(
		.MAX_SIDE (MAX_SIDE)
	) u_row (
		.north    (north_q),
		.cent     (cent_q),
		.south    (rdata_s1),
		.width    (eff_w),
		.next_row (next_row)
	);

	always_comb begin
		flip_mask       = '0;
		flip_mask[cx_q] = 1'b1;
	end

	// step writes go to the other bank, so reads and writes never meet on one row;
	// toggle writes back before the next transfer can read
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {cur_q, row_q};
		mem_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = {cur_q, row_q};
			end
			ST_ACC: begin
				mem_we    = in_field_q && (func_q == OP_TOGGLE);
				mem_waddr = {cur_q, cy_q};
				mem_wdata = rdata_s1 ^ flip_mask;
			end
			ST_STEP: begin
				mem_we    = row_wr;
				mem_waddr = {~cur_q, RW'(arr_cnt_q - CW'(2))};
				mem_wdata = next_row;
			end
			ST_ZERO: begin
				mem_we    = 1'b1;
				mem_waddr = {~cur_q, row_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	// three-row window for the step
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			north_q <= cent_q;
			cent_q  <= rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			cur_q       <= 1'b0;
			func_q      <= OP_CLEAR;
			in_field_q  <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			row_q       <= '0;
			rd_cnt_q    <= '0;
			arr_cnt_q   <= '0;
			res_alive_q <= 1'b0;
			clr_reply_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_alive_q <= 1'b0;
			rsp_op_q    <= OP_CLEAR;
			rd_v_s1     <= 1'b0;
		end else begin
			rd_v_s1 <= step_issue;
			// the finish state loads the output register itself
			if (rsp.ready && (state_q != ST_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					if (row_q == RW'(MAX_SIDE - 1)) begin
						row_q       <= '0;
						res_alive_q <= 1'b0;
						state_q     <= clr_reply_q ? ST_FIN : ST_IDLE;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						func_q     <= op_t'(req.func);
						in_field_q <= in_field;
						cx_q       <= cx_wide[RW-1:0];
						cy_q       <= cy_wide[RW-1:0];
						unique case (op_t'(req.func))
							OP_CLEAR: begin
								clr_reply_q <= 1'b1;
								row_q       <= '0;
								state_q     <= ST_CLR;
							end
							OP_TOGGLE, OP_READ: begin
								state_q <= ST_ACC;
							end
							OP_STEP: begin
								rd_cnt_q  <= '0;
								arr_cnt_q <= '0;
								state_q   <= ST_STEP;
							end
						endcase
					end
				end
				ST_ACC: begin
					res_alive_q <= in_field_q && (rdata_s1[cx_q] ^ (func_q == OP_TOGGLE));
					state_q     <= ST_FIN;
				end
				ST_STEP: begin
					if (step_issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (rd_v_s1) begin
						arr_cnt_q <= arr_cnt_q + CW'(1);
						if (arr_cnt_q == d_plus1) begin
							res_alive_q <= 1'b0;
							if (eff_d == SW'(MAX_SIDE)) begin
								cur_q   <= ~cur_q;
								state_q <= ST_FIN;
							end else begin
								row_q   <= RW'(eff_d);
								state_q <= ST_ZERO;
							end
						end
					end
				end
				ST_ZERO: begin
					// rows below the field come out dead
					if (row_q == RW'(MAX_SIDE - 1)) begin
						row_q   <= '0;
						cur_q   <= ~cur_q;
						state_q <= ST_FIN;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_alive_q <= res_alive_q;
						rsp_op_q    <= func_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cell_alive = rsp_alive_q;
	assign rsp.op_done    = rsp_op_q;

	`LGE_ASSERT_NOW(a_step_writes_other_bank, (state_q == ST_STEP) && mem_we, mem_waddr[AW-1] != cur_q, "step wrote the current grid")
	`LGE_ASSERT_NOW(a_step_read_bound, step_issue, rd_cnt_q <= d_plus1, "step read past the wrap row")
	`LGE_ASSERT_NEXT(a_bank_swap_only_on_step, (state_q != ST_STEP) && (state_q != ST_ZERO), $stable(cur_q), "grid banks swapped outside a step")
	`LGE_ASSERT_NEXT(a_result_only_from_finish, (state_q != ST_FIN) && !rsp_valid_q, !rsp_valid_q, "result raised without a finished operation")
	`LGE_ASSERT_NOW(a_no_read_while_busy, (state_q != ST_IDLE) && (state_q != ST_STEP), !mem_re, "grid read issued while an operation is busy")

endmodule

`default_nettype wire
